// ===== src/clock_date_time_field_editor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Clock date/time field editor assertion macros
// Shared assertion forms for the checker of the field editor.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DATE_TIME_FIELD_EDITOR_TOP_DEFINES_SVH
`define CLOCK_DATE_TIME_FIELD_EDITOR_TOP_DEFINES_SVH

// Property checked only while the block is out of reset.
`define CDTFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CDTFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cdtfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock date/time field editor package
// Field codes, range limits and the wrap helpers of the field editor.
// ----------------------------------------------------------------------------
package cdtfe_pkg;

  localparam int REPEAT_PERIOD = 4;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd40;

  typedef logic [2:0] field_sel_t;

  localparam field_sel_t FIELD_HOUR    = 3'd0;
  localparam field_sel_t FIELD_MINUTE  = 3'd1;
  localparam field_sel_t FIELD_SECOND  = 3'd2;
  localparam field_sel_t FIELD_WEEKDAY = 3'd3;
  localparam field_sel_t FIELD_DATE    = 3'd4;
  localparam field_sel_t FIELD_MONTH   = 3'd5;
  localparam field_sel_t FIELD_YEAR    = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINSEC_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MIN = 7'd1;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] DATE_MIN    = 7'd1;
  localparam logic [6:0] MONTH_MIN   = 7'd1;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;

  // Months that are out of range count as 31 days long.
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                      len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
    return (v >= hi) ? lo : v + 7'd1;
  endfunction

  function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    return ((v <= lo) || (v > hi)) ? hi : v - 7'd1;
  endfunction

  // A press steps on its first tick, then every REPEAT_PERIOD ticks past the threshold.
  function automatic logic press_fires(input logic [15:0] count, input logic [15:0] thresh);
    return (count == 16'd1) ||
           ((count > thresh) && ((count % 16'(REPEAT_PERIOD)) == 16'd0));
  endfunction

endpackage

// ===== src/clock_date_time_field_editor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock date/time field editor
// Edits a seven-field time and date with up, down and next button ticks, or loads it whole.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    cmd, button counts, load snapshot
//  out_     output     out_valid/out_ready  seven fields, selected_field
//  cfg_     input      cfg_valid/cfg_ready  long_press_ticks
//
// One request is accepted per cycle while the result is not stalled; each
// passes through the input register, then through the step logic into the
// field registers, which are also the result register.
// A stalled result holds the field registers and, once the input register
// is full too, drops in_ready. Synchronous reset clears the fields to
// 00:00:00, Monday, 1 January, year 00, hour selected, threshold 40.
// ----------------------------------------------------------------------------
module clock_date_time_field_editor_top
  import cdtfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_long_press_ticks,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_up_count,
  input  logic [15:0] in_down_count,
  input  logic [15:0] in_next_count,
  input  logic [4:0]  in_load_hour,
  input  logic [5:0]  in_load_minute,
  input  logic [5:0]  in_load_second,
  input  logic [2:0]  in_load_weekday,
  input  logic [4:0]  in_load_date,
  input  logic [3:0]  in_load_month,
  input  logic [6:0]  in_load_year,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_date,
  output logic [3:0]  out_month,
  output logic [6:0]  out_year,
  output logic [2:0]  out_selected_field
);

  logic [15:0] long_press_r;

  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [15:0] s1_up_r;
  logic [15:0] s1_dn_r;
  logic [15:0] s1_nx_r;
  logic [4:0]  s1_hour_r;
  logic [5:0]  s1_minute_r;
  logic [5:0]  s1_second_r;
  logic [2:0]  s1_weekday_r;
  logic [4:0]  s1_date_r;
  logic [3:0]  s1_month_r;
  logic [6:0]  s1_year_r;

  logic        out_valid_r;
  logic [4:0]  hour_r,    hour_nxt;
  logic [5:0]  minute_r,  minute_nxt;
  logic [5:0]  second_r,  second_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic [4:0]  date_r,    date_nxt;
  logic [3:0]  month_r,   month_nxt;
  logic [6:0]  year_r,    year_nxt;
  field_sel_t  sel_r,     sel_nxt;

  logic        advance;
  logic        in_fire;

  logic [6:0]  cur;
  logic [6:0]  lo;
  logic [6:0]  hi;
  logic [6:0]  after_up;
  logic [6:0]  after_dn;
  logic        sel_ok;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;

  // Limits of the field that was selected before this request.
  always_comb begin
    cur    = 7'd0;
    lo     = 7'd0;
    hi     = 7'd0;
    sel_ok = 1'b1;
    case (sel_r)
      FIELD_HOUR: begin
        cur = {2'b00, hour_r};
        hi  = HOUR_MAX;
      end
      FIELD_MINUTE: begin
        cur = {1'b0, minute_r};
        hi  = MINSEC_MAX;
      end
      FIELD_SECOND: begin
        cur = {1'b0, second_r};
        hi  = MINSEC_MAX;
      end
      FIELD_WEEKDAY: begin
        cur = {4'b0000, weekday_r};
        lo  = WEEKDAY_MIN;
        hi  = WEEKDAY_MAX;
      end
      FIELD_DATE: begin
        cur = {2'b00, date_r};
        lo  = DATE_MIN;
        hi  = {2'b00, month_length(month_r, year_r)};
      end
      FIELD_MONTH: begin
        cur = {3'b000, month_r};
        lo  = MONTH_MIN;
        hi  = MONTH_MAX;
      end
      FIELD_YEAR: begin
        cur = year_r;
        hi  = YEAR_MAX;
      end
      default: begin
        sel_ok = 1'b0;
      end
    endcase
    after_up = press_fires(s1_up_r, long_press_r) ? wrap_up(cur, lo, hi) : cur;
    after_dn = press_fires(s1_dn_r, long_press_r) ? wrap_down(after_up, lo, hi) : after_up;
  end

  always_comb begin
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    weekday_nxt = weekday_r;
    date_nxt    = date_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    sel_nxt     = sel_r;
    if (s1_cmd_r == CMD_LOAD) begin
      hour_nxt    = s1_hour_r;
      minute_nxt  = s1_minute_r;
      second_nxt  = s1_second_r;
      weekday_nxt = s1_weekday_r;
      date_nxt    = s1_date_r;
      month_nxt   = s1_month_r;
      year_nxt    = s1_year_r;
      sel_nxt     = FIELD_HOUR;
    end else begin
      if (sel_ok) begin
        case (sel_r)
          FIELD_HOUR:    hour_nxt    = after_dn[4:0];
          FIELD_MINUTE:  minute_nxt  = after_dn[5:0];
          FIELD_SECOND:  second_nxt  = after_dn[5:0];
          FIELD_WEEKDAY: weekday_nxt = after_dn[2:0];
          FIELD_DATE:    date_nxt    = after_dn[4:0];
          FIELD_MONTH:   month_nxt   = after_dn[3:0];
          FIELD_YEAR:    year_nxt    = after_dn;
          default:       year_nxt    = year_r;
        endcase
      end
      // Next only reacts to the first tick of a press, with no auto-repeat.
      if (s1_nx_r == 16'd1) begin
        sel_nxt = (sel_r >= FIELD_YEAR) ? FIELD_HOUR : sel_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      hour_r       <= 5'd0;
      minute_r     <= 6'd0;
      second_r     <= 6'd0;
      weekday_r    <= 3'd1;
      date_r       <= 5'd1;
      month_r      <= 4'd1;
      year_r       <= 7'd0;
      sel_r        <= FIELD_HOUR;
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_press_r <= cfg_long_press_ticks;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        second_r    <= second_nxt;
        weekday_r   <= weekday_nxt;
        date_r      <= date_nxt;
        month_r     <= month_nxt;
        year_r      <= year_nxt;
        sel_r       <= sel_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_cmd;
      s1_up_r      <= in_up_count;
      s1_dn_r      <= in_down_count;
      s1_nx_r      <= in_next_count;
      s1_hour_r    <= in_load_hour;
      s1_minute_r  <= in_load_minute;
      s1_second_r  <= in_load_second;
      s1_weekday_r <= in_load_weekday;
      s1_date_r    <= in_load_date;
      s1_month_r   <= in_load_month;
      s1_year_r    <= in_load_year;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hour           = hour_r;
  assign out_minute         = minute_r;
  assign out_second         = second_r;
  assign out_weekday        = weekday_r;
  assign out_date           = date_r;
  assign out_month          = month_r;
  assign out_year           = year_r;
  assign out_selected_field = sel_r;

endmodule

// ===== src/cdtfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock date/time field editor checker
// Port-level assertions on the field editor, attached by bind.
// ----------------------------------------------------------------------------
`include "clock_date_time_field_editor_top_defines.svh"

module cdtfe_checker
  import cdtfe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic [4:0]  in_load_hour,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_hour,
  input logic [2:0]  out_selected_field
);

  // No result is offered in the cycle after reset.
  `CDTFE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // The selection never leaves the seven fields.
  `CDTFE_ASSERT(a_sel_range, out_valid |-> (out_selected_field <= FIELD_YEAR), "selection out of range")

  // A stalled result keeps its fields.
  `CDTFE_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_hour) && $stable(out_selected_field)), "stalled result changed")

  // With out_ready held, a load passes the input and field registers to the output.
  `CDTFE_ASSERT(a_load_latency, (in_valid && in_ready && (in_cmd == CMD_LOAD) && out_ready) ##1 out_ready |=> (out_valid && (out_selected_field == FIELD_HOUR) && (out_hour == $past(in_load_hour, 2))), "load request not delivered in order")

endmodule

bind clock_date_time_field_editor_top cdtfe_checker u_cdtfe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_cmd             (in_cmd),
  .in_load_hour       (in_load_hour),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_hour           (out_hour),
  .out_selected_field (out_selected_field)
);
